[rtl/pffca_pkg.sv]
// Package of types and constants for the paged first-fit chunk allocator.
package pffca_pkg;

	localparam int MAX_PAGES  = 8;
	localparam int MAX_CHUNKS = 64;
	localparam int PAGE_W     = $clog2(MAX_PAGES);
	localparam int CHUNK_W    = $clog2(MAX_CHUNKS);
	localparam int SLOT_W     = PAGE_W + CHUNK_W;
	localparam int LEN_W      = 7;
	localparam int OPEN_W     = PAGE_W + 1;
	localparam int ENTRY_W    = LEN_W + 2;
	localparam int CHUNK_SH   = 10;

	localparam logic [OPEN_W-1:0] PAGES_FULL = OPEN_W'(MAX_PAGES);
	localparam logic [LEN_W-1:0]  CHUNKS_MAX = LEN_W'(MAX_CHUNKS);

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_SIZE   = 2'd1,
		ST_FULL       = 2'd2,
		ST_BAD_HANDLE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PAGE_CHK,
		S_SCAN_RD,
		S_SCAN_EV,
		S_NOFIT,
		S_CLEAR,
		S_SPLIT,
		S_TAKE,
		S_REL_RD,
		S_REL_EV,
		S_MRG_RD,
		S_MRG_EV,
		S_REL_WR,
		S_DONE
	} state_t;

	// One segment table entry: head mark, free mark, length in chunks.
	typedef struct packed {
		logic             head;
		logic             free;
		logic [LEN_W-1:0] len;
	} entry_t;

endpackage

[rtl/paged_first_fit_chunk_allocator_core.sv]
// Top level of the paged first-fit chunk allocator with merging on release.
// An allocate checks the free count of each open page, walks the segment heads of a page that
//   may fit, and opens and clears a new page when none fits; a release merges the free
//   neighbors that follow it. A finished result waits in S_DONE while the output register is held.
//   One item at a time, set by the single RAM port.
// Reset: arst_n clears control state, pages_open and sets chunks_per_page to 64;
//   the segment RAM is not cleared, a page is cleared when it is opened.
module paged_first_fit_chunk_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [16:0]                   size_bytes,
	input  logic [pffca_pkg::PAGE_W-1:0]  release_page,
	input  logic [pffca_pkg::CHUNK_W-1:0] release_chunk,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [pffca_pkg::PAGE_W-1:0]  page,
	output logic [15:0]                   byte_offset,
	output logic [16:0]                   section_bytes,
	output logic [pffca_pkg::CHUNK_W-1:0] handle_chunk,
	output logic                          opened_page,
	input  logic                          cfg_we,
	input  logic [pffca_pkg::LEN_W-1:0]   cfg_wdata
);
	import pffca_pkg::*;

	state_t state_q, state_d;

	logic [LEN_W-1:0]   cpp_q;
	logic [LEN_W-1:0]   cpp_eff;
	logic [OPEN_W-1:0]  pages_open_q, pages_open_d;
	logic [LEN_W-1:0]   pfc_q [MAX_PAGES];
	logic [LEN_W-1:0]   pfc_d [MAX_PAGES];
	logic [OPEN_W-1:0]  p_q, p_d;
	logic [7:0]         pos_q, pos_d;
	logic [CHUNK_W-1:0] base_q, base_d;
	logic [LEN_W-1:0]   need_q, need_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [CHUNK_W-1:0] cnt_q, cnt_d;
	logic               opened_q, opened_d;
	logic               alloc_q, alloc_d;
	status_t            res_q, res_d;

	logic               out_valid_q;
	status_t            status_q;
	logic [PAGE_W-1:0]  page_q;
	logic [15:0]        byte_offset_q;
	logic [16:0]        section_bytes_q;
	logic [CHUNK_W-1:0] handle_chunk_q;
	logic               opened_page_q;
	logic               load_out;

	logic [17:0]        size_up;
	logic [7:0]         need_full;
	logic [7:0]         pos_sum;

	logic               ram_we;
	logic [SLOT_W-1:0]  ram_addr;
	entry_t             ram_wdata;
	entry_t             ram_rdata;
	logic [ENTRY_W-1:0] ram_rraw;

	pffca_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PAGES * MAX_CHUNKS)) u_seg_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rraw)
	);
	assign ram_rdata = entry_t'(ram_rraw);

	// Clamp the page size register to the legal range.
	always_comb begin
		if (cpp_q == '0) begin
			cpp_eff = LEN_W'(1);
		end else if (cpp_q > CHUNKS_MAX) begin
			cpp_eff = CHUNKS_MAX;
		end else begin
			cpp_eff = cpp_q;
		end
	end

	// Round bytes up to whole 1024-byte chunks.
	assign size_up   = {1'b0, size_bytes} + 18'd1023;
	assign need_full = size_up[17:CHUNK_SH];

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		pages_open_d = pages_open_q;
		pfc_d        = pfc_q;
		p_d          = p_q;
		pos_d        = pos_q;
		base_d       = base_q;
		need_d       = need_q;
		len_d        = len_q;
		cnt_d        = cnt_q;
		opened_d     = opened_q;
		alloc_d      = alloc_q;
		res_d        = res_q;
		ram_we       = 1'b0;
		ram_addr     = {p_q[PAGE_W-1:0], pos_q[CHUNK_W-1:0]};
		ram_wdata    = '0;
		pos_sum      = pos_q + {1'b0, ram_rdata.len};
		load_out     = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					opened_d = 1'b0;
					alloc_d  = 1'b0;
					res_d    = ST_OK;
					if (action == 1'b0) begin
						need_d = need_full[LEN_W-1:0];
						if (need_full == '0 || need_full > {1'b0, cpp_eff}) begin
							res_d   = ST_BAD_SIZE;
							state_d = S_DONE;
						end else begin
							p_d     = '0;
							state_d = S_PAGE_CHK;
						end
					end else begin
						p_d    = {1'b0, release_page};
						base_d = release_chunk;
						if ({1'b0, release_page} >= pages_open_q) begin
							res_d   = ST_BAD_HANDLE;
							state_d = S_DONE;
						end else begin
							state_d = S_REL_RD;
						end
					end
				end
			end
			S_PAGE_CHK: begin
				// Skip pages whose free count is too small.
				if (p_q >= pages_open_q) begin
					state_d = S_NOFIT;
				end else if (need_q <= pfc_q[p_q[PAGE_W-1:0]]) begin
					pos_d   = '0;
					state_d = S_SCAN_RD;
				end else begin
					p_d = p_q + OPEN_W'(1);
				end
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				if (!ram_rdata.head || ram_rdata.len == '0) begin
					p_d     = p_q + OPEN_W'(1);
					state_d = S_PAGE_CHK;
				end else if (ram_rdata.free && ram_rdata.len >= need_q) begin
					len_d   = ram_rdata.len;
					state_d = S_SPLIT;
				end else if (pos_sum >= 8'(MAX_CHUNKS)) begin
					p_d     = p_q + OPEN_W'(1);
					state_d = S_PAGE_CHK;
				end else begin
					pos_d   = pos_sum;
					state_d = S_SCAN_RD;
				end
			end
			S_NOFIT: begin
				if (pages_open_q == PAGES_FULL) begin
					res_d   = ST_FULL;
					state_d = S_DONE;
				end else begin
					p_d     = pages_open_q;
					cnt_d   = '0;
					state_d = S_CLEAR;
				end
			end
			S_CLEAR: begin
				// Wipe the new page, then treat it as one free segment.
				ram_we   = 1'b1;
				ram_addr = {p_q[PAGE_W-1:0], cnt_q};
				cnt_d    = cnt_q + CHUNK_W'(1);
				if (cnt_q == CHUNK_W'(MAX_CHUNKS - 1)) begin
					len_d                       = cpp_eff;
					pos_d                       = '0;
					opened_d                    = 1'b1;
					pages_open_d                = pages_open_q + OPEN_W'(1);
					pfc_d[p_q[PAGE_W-1:0]]      = cpp_eff;
					state_d                     = S_SPLIT;
				end
			end
			S_SPLIT: begin
				if (len_q > need_q) begin
					ram_we         = 1'b1;
					ram_addr       = {p_q[PAGE_W-1:0],
						pos_q[CHUNK_W-1:0] + need_q[CHUNK_W-1:0]};
					ram_wdata.head = 1'b1;
					ram_wdata.free = 1'b1;
					ram_wdata.len  = len_q - need_q;
				end
				state_d = S_TAKE;
			end
			S_TAKE: begin
				ram_we                 = 1'b1;
				ram_wdata.head         = 1'b1;
				ram_wdata.free         = 1'b0;
				ram_wdata.len          = need_q;
				pfc_d[p_q[PAGE_W-1:0]] = pfc_q[p_q[PAGE_W-1:0]] - need_q;
				alloc_d                = 1'b1;
				state_d                = S_DONE;
			end
			S_REL_RD: begin
				ram_addr = {p_q[PAGE_W-1:0], base_q};
				state_d  = S_REL_EV;
			end
			S_REL_EV: begin
				ram_addr = {p_q[PAGE_W-1:0], base_q};
				pos_sum  = {2'b0, base_q} + {1'b0, ram_rdata.len};
				if (!ram_rdata.head || ram_rdata.free) begin
					res_d   = ST_BAD_HANDLE;
					state_d = S_DONE;
				end else begin
					len_d                  = ram_rdata.len;
					pfc_d[p_q[PAGE_W-1:0]] = pfc_q[p_q[PAGE_W-1:0]] + ram_rdata.len;
					pos_d                  = pos_sum;
					if (ram_rdata.len == '0 || pos_sum >= 8'(MAX_CHUNKS)) begin
						state_d = S_REL_WR;
					end else begin
						state_d = S_MRG_RD;
					end
				end
			end
			S_MRG_RD: begin
				state_d = S_MRG_EV;
			end
			S_MRG_EV: begin
				// Absorb the following free segment and drop its head.
				if (!ram_rdata.head || !ram_rdata.free || ram_rdata.len == '0) begin
					state_d = S_REL_WR;
				end else begin
					ram_we        = 1'b1;
					ram_wdata.len = ram_rdata.len;
					len_d         = len_q + ram_rdata.len;
					if (pos_sum >= 8'(MAX_CHUNKS)) begin
						state_d = S_REL_WR;
					end else begin
						pos_d   = pos_sum;
						state_d = S_MRG_RD;
					end
				end
			end
			S_REL_WR: begin
				ram_we         = 1'b1;
				ram_addr       = {p_q[PAGE_W-1:0], base_q};
				ram_wdata.head = 1'b1;
				ram_wdata.free = 1'b1;
				ram_wdata.len  = len_q;
				state_d        = S_DONE;
			end
			S_DONE: begin
				// Hold until the output register is free.
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pages_open_q <= '0;
			cpp_q        <= CHUNKS_MAX;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			pages_open_q <= pages_open_d;
			if (cfg_we) begin
				cpp_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pfc_q    <= pfc_d;
		p_q      <= p_d;
		pos_q    <= pos_d;
		base_q   <= base_d;
		need_q   <= need_d;
		len_q    <= len_d;
		cnt_q    <= cnt_d;
		opened_q <= opened_d;
		alloc_q  <= alloc_d;
		res_q    <= res_d;
		if (load_out) begin
			status_q <= res_q;
			if (alloc_q) begin
				page_q          <= p_q[PAGE_W-1:0];
				byte_offset_q   <= {pos_q[CHUNK_W-1:0], 10'b0};
				section_bytes_q <= {need_q, 10'b0};
				handle_chunk_q  <= pos_q[CHUNK_W-1:0];
				opened_page_q   <= opened_q;
			end else begin
				page_q          <= '0;
				byte_offset_q   <= '0;
				section_bytes_q <= '0;
				handle_chunk_q  <= '0;
				opened_page_q   <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign page          = page_q;
	assign byte_offset   = byte_offset_q;
	assign section_bytes = section_bytes_q;
	assign handle_chunk  = handle_chunk_q;
	assign opened_page   = opened_page_q;

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("segment RAM written while idle");

	a_pages_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pages_open_q <= PAGES_FULL)
		else $error("open page count beyond the page limit");

	a_clear_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (pages_open_q < PAGES_FULL))
		else $error("page clear started with all pages open");

	a_ok_alloc_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAKE) |-> (need_q != '0 && need_q <= len_q))
		else $error("segment taken is shorter than the request");

endmodule

[rtl/pffca_ram.sv]
// Generic single-port RAM with registered read.
module pffca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[verif/tb.sv]
// Self-checking testbench for the paged first-fit chunk allocator core.
`timescale 1ns / 100ps

module tb;
	import pffca_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int WATCHDOG    = 6000;   // page clear plus a full walk of 8 pages, with margin
	localparam int LONG_HOLD   = 400;
	localparam bit ACT_ALLOC   = 1'b0;
	localparam bit ACT_RELEASE = 1'b1;

	typedef struct packed {
		status_t             status;
		logic [PAGE_W-1:0]   page;
		logic [15:0]         byte_offset;
		logic [16:0]         section_bytes;
		logic [CHUNK_W-1:0]  handle_chunk;
		logic                opened_page;
	} result_t;

	typedef struct {
		bit                 act;
		logic [16:0]        size;
		logic [PAGE_W-1:0]  rpage;
		logic [CHUNK_W-1:0] rchunk;
		bit                 typed;
		result_t            want;
	} row_t;

	typedef struct {
		logic [PAGE_W-1:0]  page;
		logic [CHUNK_W-1:0] chunk;
	} handle_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                action = 1'b0;
	logic [16:0]         size_bytes = '0;
	logic [PAGE_W-1:0]   release_page = '0;
	logic [CHUNK_W-1:0]  release_chunk = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [1:0]          status;
	logic [PAGE_W-1:0]   page;
	logic [15:0]         byte_offset;
	logic [16:0]         section_bytes;
	logic [CHUNK_W-1:0]  handle_chunk;
	logic                opened_page;
	logic                cfg_we = 1'b0;
	logic [LEN_W-1:0]    cfg_wdata = '0;

	// Mirror of the allocator's tables, kept in step with accepted items.
	logic [LEN_W-1:0]    seg_len  [MAX_PAGES*MAX_CHUNKS];
	bit                  seg_head [MAX_PAGES*MAX_CHUNKS];
	bit                  seg_free [MAX_PAGES*MAX_CHUNKS];
	int                  page_free [MAX_PAGES];
	int                  open_pages;
	logic [LEN_W-1:0]    chunks_cfg;

	result_t             pending_q[$];
	handle_t             live_q[$];
	row_t                directed[$];
	int                  errors, idle_cycles, hold_req;
	int                  n_alloc_ok, n_release_ok, n_rejected, n_full, n_opened;

	paged_first_fit_chunk_allocator_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .size_bytes(size_bytes),
		.release_page(release_page), .release_chunk(release_chunk),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .page(page), .byte_offset(byte_offset),
		.section_bytes(section_bytes), .handle_chunk(handle_chunk),
		.opened_page(opened_page),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic int page_chunks();
		if (chunks_cfg == 0)
			return 1;
		if (chunks_cfg > MAX_CHUNKS)
			return MAX_CHUNKS;
		return chunks_cfg;
	endfunction

	// Compute the allocator's answer to one item and advance the mirror.
	function automatic result_t allocate_or_release(bit act, logic [16:0] sz,
			logic [PAGE_W-1:0] rp, logic [CHUNK_W-1:0] rc);
		result_t r;
		int need, cpp, p, pos, slot, len, nxt, ns;
		bit found;
		r = '0;
		r.status = ST_OK;
		found = 0;
		if (act == ACT_ALLOC) begin
			cpp = page_chunks();
			need = (int'(sz) + 1023) >> CHUNK_SH;
			if (need == 0 || need > cpp) begin
				r.status = ST_BAD_SIZE;
				n_rejected++;
				return r;
			end
			for (p = 0; p < open_pages; p++) begin
				if (need <= page_free[p]) begin
					pos = 0;
					while (pos < MAX_CHUNKS) begin
						slot = p * MAX_CHUNKS + pos;
						if (!seg_head[slot] || seg_len[slot] == 0)
							break;
						if (seg_free[slot] && seg_len[slot] >= need) begin
							found = 1;
							break;
						end
						pos += seg_len[slot];
					end
					if (found)
						break;
				end
			end
			if (!found) begin
				if (open_pages >= MAX_PAGES) begin
					r.status = ST_FULL;
					n_full++;
					return r;
				end
				p = open_pages;
				for (int c = 0; c < MAX_CHUNKS; c++) begin
					seg_head[p*MAX_CHUNKS+c] = 0;
					seg_free[p*MAX_CHUNKS+c] = 0;
				end
				seg_head[p*MAX_CHUNKS] = 1;
				seg_free[p*MAX_CHUNKS] = 1;
				seg_len[p*MAX_CHUNKS]  = LEN_W'(cpp);
				page_free[p] = cpp;
				open_pages++;
				pos = 0;
				r.opened_page = 1'b1;
				n_opened++;
			end
			slot = p * MAX_CHUNKS + pos;
			len = seg_len[slot];
			// split off the tail unless the segment fits exactly
			if (len > need) begin
				seg_head[slot+need] = 1;
				seg_free[slot+need] = 1;
				seg_len[slot+need]  = LEN_W'(len - need);
				seg_len[slot]       = LEN_W'(need);
			end
			seg_free[slot] = 0;
			page_free[p] -= need;
			r.page          = PAGE_W'(p);
			r.byte_offset   = 16'(pos << CHUNK_SH);
			r.section_bytes = 17'(need << CHUNK_SH);
			r.handle_chunk  = CHUNK_W'(pos);
			live_q.push_back('{page: PAGE_W'(p), chunk: CHUNK_W'(pos)});
			n_alloc_ok++;
		end else begin
			slot = rp * MAX_CHUNKS + rc;
			if (rp >= open_pages || !seg_head[slot] || seg_free[slot]) begin
				r.status = ST_BAD_HANDLE;
				n_rejected++;
				return r;
			end
			len = seg_len[slot];
			nxt = rc + len;
			page_free[rp] += len;
			seg_free[slot] = 1;
			// merge with the free segments that follow
			while (len != 0 && nxt < MAX_CHUNKS) begin
				ns = rp * MAX_CHUNKS + nxt;
				if (!seg_head[ns] || !seg_free[ns] || seg_len[ns] == 0)
					break;
				len += seg_len[ns];
				seg_head[ns] = 0;
				seg_free[ns] = 0;
				nxt += seg_len[ns];
			end
			seg_len[slot] = LEN_W'(len);
			foreach (live_q[i])
				if (live_q[i].page == rp && live_q[i].chunk == rc) begin
					live_q.delete(i);
					break;
				end
			n_release_ok++;
		end
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Offer one item, hold it until taken, then optionally drop valid for a gap.
	task automatic offer(row_t it);
		int gap, roll;
		result_t pred;
		in_valid      <= 1'b1;
		action        <= it.act;
		size_bytes    <= it.size;
		release_page  <= it.rpage;
		release_chunk <= it.rchunk;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		idle_cycles = 0;
		pred = allocate_or_release(it.act, it.size, it.rpage, it.rchunk);
		pending_q.push_back(it.typed ? it.want : pred);
		roll = $urandom_range(0, 99);
		gap = (roll < 55) ? 0 : (roll < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lower valid and hold until every expected result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic row_t pick_random();
		row_t it;
		int cpp, roll, idx;
		it = '{default: '0};
		cpp = page_chunks();
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			it.act = ACT_ALLOC;
			roll = $urandom_range(0, 99);
			if (roll < 70)
				it.size = 17'($urandom_range(1, cpp * 1024 < 8192 ? cpp * 1024 : 8192));
			else if (roll < 80)
				it.size = 17'($urandom_range(1, cpp) * 1024);
			else if (roll < 88)
				it.size = 17'($urandom_range(1, cpp * 1024));
			else if (roll < 92)
				it.size = '0;
			else
				it.size = 17'($urandom);
		end else begin
			it.act = ACT_RELEASE;
			it.size = 17'($urandom);
			if (live_q.size() != 0 && $urandom_range(0, 99) < 85) begin
				idx = $urandom_range(0, live_q.size() - 1);
				it.rpage  = live_q[idx].page;
				it.rchunk = live_q[idx].chunk;
			end else begin
				it.rpage  = PAGE_W'($urandom);
				it.rchunk = CHUNK_W'($urandom);
			end
		end
		return it;
	endfunction

	function automatic row_t row(bit act, int sz, int rp, int rc, bit typed,
			status_t st = ST_OK, int pg = 0, int off = 0, int bytes = 0,
			int hc = 0, bit op = 0);
		row_t it;
		it.act = act;
		it.size = 17'(sz);
		it.rpage = PAGE_W'(rp);
		it.rchunk = CHUNK_W'(rc);
		it.typed = typed;
		it.want = '{status: st, page: PAGE_W'(pg), byte_offset: 16'(off),
			section_bytes: 17'(bytes), handle_chunk: CHUNK_W'(hc), opened_page: op};
		return it;
	endfunction

	// Stimulus: directed table, then random phases under several page sizes.
	initial begin
		int cfg_plan[6];
		cfg_plan = '{0, 3, 127, 1, 40, 64};
		open_pages = 0;
		chunks_cfg = LEN_W'(64);
		foreach (seg_head[i]) begin
			seg_head[i] = 0;
			seg_free[i] = 0;
			seg_len[i] = '0;
		end
		foreach (page_free[i])
			page_free[i] = 0;
		errors = 0;
		hold_req = 0;

		directed.push_back(row(ACT_ALLOC,   0,      0, 0,  1, ST_BAD_SIZE));
		directed.push_back(row(ACT_ALLOC,   131071, 0, 0,  1, ST_BAD_SIZE));
		directed.push_back(row(ACT_ALLOC,   65536,  0, 0,  1, ST_OK, 0, 0, 65536, 0, 1));
		directed.push_back(row(ACT_RELEASE, 0,      7, 0,  1, ST_BAD_HANDLE));
		directed.push_back(row(ACT_RELEASE, 0,      0, 5,  1, ST_BAD_HANDLE));
		directed.push_back(row(ACT_RELEASE, 0,      0, 0,  1, ST_OK));
		directed.push_back(row(ACT_RELEASE, 0,      0, 0,  1, ST_BAD_HANDLE));
		directed.push_back(row(ACT_ALLOC,   1,      0, 0,  1, ST_OK, 0, 0, 1024, 0, 0));
		directed.push_back(row(ACT_ALLOC,   1025,   0, 0,  1, ST_OK, 0, 1024, 2048, 1, 0));
		directed.push_back(row(ACT_ALLOC,   62464,  0, 0,  1, ST_OK, 0, 3072, 62464, 3, 0));
		directed.push_back(row(ACT_ALLOC,   1024,   0, 0,  1, ST_OK, 1, 0, 1024, 0, 1));
		directed.push_back(row(ACT_RELEASE, 0,      0, 1,  1, ST_OK));
		directed.push_back(row(ACT_RELEASE, 0,      0, 0,  1, ST_OK));
		directed.push_back(row(ACT_ALLOC,   3072,   0, 0,  1, ST_OK, 0, 0, 3072, 0, 0));
		directed.push_back(row(ACT_RELEASE, 0,      1, 63, 1, ST_BAD_HANDLE));
		directed.push_back(row(ACT_ALLOC,   65535,  0, 0,  1, ST_OK, 2, 0, 65536, 0, 1));
		directed.push_back(row(ACT_RELEASE, 0,      2, 0,  1, ST_OK));
		directed.push_back(row(ACT_ALLOC,   2048,   0, 0,  0));
		directed.push_back(row(ACT_RELEASE, 0,      1, 0,  0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer(directed[i]);

		foreach (cfg_plan[ph]) begin
			// hold stimulus until the block is idle, then change page size
			drain();
			cfg_we    <= 1'b1;
			cfg_wdata <= LEN_W'(cfg_plan[ph]);
			chunks_cfg = LEN_W'(cfg_plan[ph]);
			@(posedge clk);
			cfg_we <= 1'b0;
			if (ph == 1)
				hold_req = 1;
			repeat (215)
				offer(pick_random());
		end
		drain();
		repeat (20) @(posedge clk);

		$display("Ran %0d allocations, %0d releases, %0d rejects, %0d heap-full answers,",
			n_alloc_ok, n_release_ok, n_rejected, n_full);
		$display("%0d page openings over six page sizes including 0, 1, 64 and 127.",
			n_opened);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Result side: random back-pressure, one long hold-off on request.
	initial begin
		int roll, hold;
		result_t exp_r;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				idle_cycles = 0;
				if (pending_q.size() == 0) begin
					$display("%0t: result with nothing expected, status %0d", $time, status);
					errors++;
				end else begin
					exp_r = pending_q.pop_front();
					check_field("status",        exp_r.status,        status);
					check_field("page",          exp_r.page,          page);
					check_field("byte_offset",   exp_r.byte_offset,   byte_offset);
					check_field("section_bytes", exp_r.section_bytes, section_bytes);
					check_field("handle_chunk",  exp_r.handle_chunk,  handle_chunk);
					check_field("opened_page",   exp_r.opened_page,   opened_page);
				end
			end
			if (hold_req != 0) begin
				hold_req = 0;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 65)
					out_ready <= 1'b1;
				else begin
					out_ready <= 1'b0;
					if (roll >= 95)
						hold = $urandom_range(10, 80);
					else
						hold = $urandom_range(0, 3);
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("%0t: no handshake for %0d cycles", $time, WATCHDOG);
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
